// ===== rtl/core/page_framebuffer_pixel_engine_defines.svh =====
// Assertion macros for the page framebuffer pixel engine.
`ifndef PAGE_FRAMEBUFFER_PIXEL_ENGINE_DEFINES_SVH
`define PAGE_FRAMEBUFFER_PIXEL_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define PFB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pfb assertion failed");

// Next-cycle implication, disabled while reset is held.
`define PFB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pfb assertion failed");

`endif

// ===== rtl/core/pfb_pkg.sv =====
// Shared types and constants for the page framebuffer pixel engine.
package pfb_pkg;

    // Operation codes; the fourth code is unused and only loads a result with updated clear.
    typedef enum logic [1:0] {
        OP_PIXEL = 2'd0,
        OP_BYTE  = 2'd1,
        OP_FILL  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PIXEL,
        ST_FILL
    } t_state;

    // Pixel bit for row 0 of a page.
    localparam logic [7:0] PIX_BIT0 = 8'h01;

    // Decoded pixel op, carried from decode into the read-modify-write stage.
    typedef struct packed {
        logic [2:0] page;
        logic [6:0] column;
        logic [7:0] mask;
        logic       color;
    } t_pix_info;

endpackage

// ===== rtl/core/pfb_decode.sv =====
// Coordinate clamping, range check and address generation.
module pfb_decode
    import pfb_pkg::*;
#(
    parameter int PAGES   = 8,
    parameter int COLUMNS = 128,
    parameter int AW      = 10
) (
    input  logic [7:0]    i_pixel_x,
    input  logic [7:0]    i_pixel_y,
    input  logic          i_color,
    input  logic [7:0]    i_page_index,
    input  logic [7:0]    i_column_index,
    output logic [AW-1:0] o_pix_addr,
    output t_pix_info     o_pix_info,
    output logic [AW-1:0] o_byte_addr,
    output logic          o_byte_ok
);

    localparam logic [7:0] XMAX = 8'(COLUMNS - 1);
    localparam logic [7:0] YMAX = 8'(PAGES * 8 - 1);

    logic [7:0] x_c;
    logic [7:0] y_c;

    assign x_c = (i_pixel_x > XMAX) ? XMAX : i_pixel_x;
    assign y_c = (i_pixel_y > YMAX) ? YMAX : i_pixel_y;

    // page = y / 8, bit = y mod 8
    assign o_pix_addr = AW'(y_c[7:3]) * AW'(COLUMNS) + AW'(x_c);

    assign o_pix_info.page   = y_c[5:3];
    assign o_pix_info.column = x_c[6:0];
    assign o_pix_info.mask   = PIX_BIT0 << y_c[2:0];
    assign o_pix_info.color  = i_color;

    assign o_byte_ok   = ({1'b0, i_page_index} < 9'(PAGES))
                      && ({1'b0, i_column_index} < 9'(COLUMNS));
    assign o_byte_addr = AW'(i_page_index) * AW'(COLUMNS) + AW'(i_column_index);

endmodule

// ===== rtl/core/pfb_store.sv =====
// Frame store: single-write, single-read synchronous byte memory.
module pfb_store
    import pfb_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/page_framebuffer_pixel_engine.sv =====
// Top level of the page framebuffer pixel engine: control, store and result register.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------------------
//  in      | into      | i_in_valid / o_in_stall   | op, pixel_x/y, color, page/column, byte
//  out     | out of    | o_out_valid / i_out_stall | out_page, out_column, out_byte, updated
//
// Pixel op: a store read on the transfer, then the write-back of the modified byte in ST_PIXEL.
// Byte write and the unused op code: result loaded on the transfer edge.
// Fill: one store write per cycle over every entry, the result loaded with the last write.
// After reset the store is cleared by a sweep over all PAGES*COLUMNS entries (1024 by default);
// no transfer is taken in until it ends. A stalled result blocks the next transfer.
`include "page_framebuffer_pixel_engine_defines.svh"

module page_framebuffer_pixel_engine
    import pfb_pkg::*;
#(
    parameter int PAGES   = 8,
    parameter int COLUMNS = 128
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_op,
    input  logic [7:0] i_pixel_x,
    input  logic [7:0] i_pixel_y,
    input  logic       i_color,
    input  logic [7:0] i_page_index,
    input  logic [7:0] i_column_index,
    input  logic [7:0] i_byte_value,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [2:0] o_out_page,
    output logic [6:0] o_out_column,
    output logic [7:0] o_out_byte,
    output logic       o_updated
);

    localparam int            DEPTH = PAGES * COLUMNS;
    localparam int            AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST  = AW'(DEPTH - 1);

    // Control state
    t_state        r_state, n_state;
    logic [AW-1:0] r_sweep;
    logic [7:0]    r_fill;
    logic          r_out_valid;

    // Payload held across the read-modify-write
    logic [AW-1:0] r_addr;
    t_pix_info     r_info;

    // Result register
    logic [2:0]    r_out_page;
    logic [6:0]    r_out_column;
    logic [7:0]    r_out_byte;
    logic          r_out_updated;

    // Decode
    logic [AW-1:0] pix_addr;
    logic [AW-1:0] byte_addr;
    t_pix_info     pix_info;
    logic          byte_ok;

    // Store access
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic          mem_re;
    logic [7:0]    mem_rdata;
    logic [7:0]    pix_byte;

    // Result load
    logic          out_load;
    logic [2:0]    ld_page;
    logic [6:0]    ld_column;
    logic [7:0]    ld_byte;
    logic          ld_updated;

    logic          in_xfer;
    logic          out_xfer;
    logic          sweep_end;

    // Only take an item while idle and the result register is free or emptying.
    assign o_in_stall = (r_state != ST_IDLE) || (r_out_valid && i_out_stall);
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign out_xfer   = r_out_valid && !i_out_stall;
    assign sweep_end  = (r_sweep == LAST);

    pfb_decode #(
        .PAGES   (PAGES),
        .COLUMNS (COLUMNS),
        .AW      (AW)
    ) u_decode (
        .i_pixel_x      (i_pixel_x),
        .i_pixel_y      (i_pixel_y),
        .i_color        (i_color),
        .i_page_index   (i_page_index),
        .i_column_index (i_column_index),
        .o_pix_addr     (pix_addr),
        .o_pix_info     (pix_info),
        .o_byte_addr    (byte_addr),
        .o_byte_ok      (byte_ok)
    );

    pfb_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (pix_addr),
        .o_rdata (mem_rdata)
    );

    // Modified byte; read data arrives the cycle after the transfer.
    assign pix_byte = r_info.color ? (mem_rdata | r_info.mask) : (mem_rdata & ~r_info.mask);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (sweep_end) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_xfer) begin
                    case (t_op'(i_op))
                        OP_PIXEL: n_state = ST_PIXEL;
                        OP_FILL:  n_state = ST_FILL;
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_PIXEL: n_state = ST_IDLE;
            ST_FILL: begin
                if (sweep_end) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // Store access and result load
    always_comb begin
        mem_we     = 1'b0;
        mem_waddr  = r_sweep;
        mem_wdata  = r_fill;
        mem_re     = 1'b0;
        out_load   = 1'b0;
        ld_page    = '0;
        ld_column  = '0;
        ld_byte    = '0;
        ld_updated = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_wdata = '0;
            end
            ST_IDLE: begin
                if (in_xfer) begin
                    case (t_op'(i_op))
                        OP_PIXEL: mem_re = 1'b1;
                        OP_BYTE: begin
                            out_load = 1'b1;
                            if (byte_ok) begin
                                mem_we     = 1'b1;
                                mem_waddr  = byte_addr;
                                mem_wdata  = i_byte_value;
                                ld_page    = i_page_index[2:0];
                                ld_column  = i_column_index[6:0];
                                ld_byte    = i_byte_value;
                                ld_updated = 1'b1;
                            end
                        end
                        OP_FILL: ;
                        default: out_load = 1'b1;
                    endcase
                end
            end
            ST_PIXEL: begin
                mem_we     = 1'b1;
                mem_waddr  = r_addr;
                mem_wdata  = pix_byte;
                out_load   = 1'b1;
                ld_page    = r_info.page;
                ld_column  = r_info.column;
                ld_byte    = pix_byte;
                ld_updated = 1'b1;
            end
            ST_FILL: begin
                mem_we = 1'b1;
                if (sweep_end) begin
                    out_load   = 1'b1;
                    ld_byte    = r_fill;
                    ld_updated = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_sweep     <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR || r_state == ST_FILL) begin
                r_sweep <= r_sweep + AW'(1);
            end else if (in_xfer && i_op == OP_FILL) begin
                r_sweep <= '0;
                r_fill  <= i_byte_value;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_xfer) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_addr <= pix_addr;
            r_info <= pix_info;
        end
        if (out_load) begin
            r_out_page    <= ld_page;
            r_out_column  <= ld_column;
            r_out_byte    <= ld_byte;
            r_out_updated <= ld_updated;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_page   = r_out_page;
    assign o_out_column = r_out_column;
    assign o_out_byte   = r_out_byte;
    assign o_updated    = r_out_updated;

    // The write-back cycle of a pixel op loads an updated result.
    `PFB_ASSERT_NXT(a_pixel_result, i_clk, i_rst_n, r_state == ST_PIXEL, r_out_valid && r_out_updated)
    // The write-back goes to the entry that was read.
    `PFB_ASSERT_IMP(a_wb_addr, i_clk, i_rst_n, r_state == ST_PIXEL, mem_we && mem_waddr == $past(pix_addr))
    // Reads and writes never share a cycle.
    `PFB_ASSERT_IMP(a_no_rw_overlap, i_clk, i_rst_n, mem_re, !mem_we)
    // The last fill write is followed by the fill result.
    `PFB_ASSERT_NXT(a_fill_result, i_clk, i_rst_n, r_state == ST_FILL && sweep_end, r_out_valid && r_out_byte == $past(r_fill))

endmodule
